@@ sv/rsp_pkg.sv @@
// shared types, constants and GF(256) arithmetic for the reed-solomon parity encoder
// no dependencies; the front, queue, back, top and testbench files import this package

package rsp_pkg;

  // largest supported parity count and derived widths
  localparam int MAX_PARITY   = 32;
  localparam int CNT_W        = $clog2(MAX_PARITY + 1);
  localparam int IDX_W        = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
  localparam int CFG_W        = 6;
  localparam int RESET_PARITY = 10;

  // field polynomial 0x11d without its x^8 term, and the primitive element
  localparam logic [7:0] FIELD_POLY_LO = 8'h1D;
  localparam logic [7:0] GF_ALPHA      = 8'h02;

  typedef logic [7:0]                     gf_byte_t;
  typedef gf_byte_t [MAX_PARITY-1:0]      gf_vec_t;
  typedef logic [CNT_W-1:0]               cnt_t;
  typedef logic [IDX_W-1:0]               idx_t;

  // GF(256) multiply, msb-first shift and add
  function automatic gf_byte_t gf_mul(gf_byte_t x, gf_byte_t y);
    gf_byte_t acc;
    acc = '0;
    for (int b = 7; b >= 0; b--) begin
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? FIELD_POLY_LO : 8'h00);
      acc = acc ^ (y[b] ? x : 8'h00);
    end
    return acc;
  endfunction

  // saturate a written parity count into 1..MAX_PARITY
  function automatic cnt_t clamp_count(logic [CFG_W-1:0] v);
    cnt_t c;
    if (v == '0) begin
      c = cnt_t'(1);
    end else if (int'(v) > MAX_PARITY) begin
      c = cnt_t'(MAX_PARITY);
    end else begin
      c = cnt_t'(v);
    end
    return c;
  endfunction

  // starting generator for a count d: a single 1 at position d-1
  function automatic gf_vec_t gen_seed(cnt_t d);
    gf_vec_t g;
    idx_t    pos;
    g        = '0;
    pos      = idx_t'(d - cnt_t'(1));
    g[pos]   = 8'h01;
    return g;
  endfunction

endpackage

@@ sv/rsp_in_if.sv @@
// message byte channel: valid/ready handshake with data byte and last flag
// no dependencies

interface rsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ sv/rsp_out_if.sv @@
// parity byte channel: valid/ready handshake with parity byte and last flag
// no dependencies

interface rsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] parity_byte;
  logic       last_parity;

  modport source (output valid, output parity_byte, output last_parity, input ready);
  modport sink   (input valid, input parity_byte, input last_parity, output ready);
endinterface

@@ sv/rsp_front.sv @@
// front end: generator build after reset or config write, and the parallel remainder lfsr
// depends on rsp_pkg and rsp_in_if; hands finished remainders to rsp_queue

module rsp_front import rsp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  rsp_in_if.sink          in_ch,
  input  logic            q_full,
  input  logic            q_take,
  output logic            q_wr_en,
  output gf_vec_t         q_wr_data,
  output cnt_t            count
);

  typedef enum logic {ST_BUILD, ST_RUN} state_t;

  state_t   state_r;
  cnt_t     count_r;
  cnt_t     iter_r;
  gf_byte_t root_r;
  gf_vec_t  gen_r;
  gf_vec_t  rem_r;

  cnt_t     cfg_count;
  gf_byte_t factor;
  gf_byte_t mul_op;
  gf_vec_t  prod;
  gf_vec_t  gen_nxt;
  gf_vec_t  rem_nxt;
  logic     in_xfer;

  // multipliers are shared: root during build, feedback factor while running
  always_comb begin
    cfg_count = clamp_count(cfg_wr_data);
    factor    = in_ch.data_byte ^ rem_r[0];
    mul_op    = (state_r == ST_BUILD) ? root_r : factor;
    for (int j = 0; j < MAX_PARITY; j++) begin
      prod[j] = gf_mul(gen_r[j], mul_op);
    end
    // entries at and past the count stay zero, so a plain byte shift suffices
    gen_nxt = prod ^ (gen_r >> 8);
    rem_nxt = prod ^ (rem_r >> 8);
  end

  // input handshake: hold off while building or when the queue cannot take a remainder
  assign in_ch.ready = (state_r == ST_RUN) && (!q_full || q_take);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign q_wr_en     = in_xfer && in_ch.last_byte;
  assign q_wr_data   = rem_nxt;
  assign count       = count_r;

  // state, generator build and remainder update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BUILD;
      count_r <= cnt_t'(RESET_PARITY);
      iter_r  <= '0;
      root_r  <= 8'h01;
      gen_r   <= gen_seed(cnt_t'(RESET_PARITY));
      rem_r   <= '0;
    end else if (cfg_wr_en) begin
      state_r <= ST_BUILD;
      count_r <= cfg_count;
      iter_r  <= '0;
      root_r  <= 8'h01;
      gen_r   <= gen_seed(cfg_count);
      rem_r   <= '0;
    end else begin
      unique case (state_r)
        ST_BUILD: begin
          gen_r  <= gen_nxt;
          root_r <= gf_mul(root_r, GF_ALPHA);
          iter_r <= iter_r + cnt_t'(1);
          if (iter_r == count_r - cnt_t'(1)) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (in_xfer) begin
            rem_r <= in_ch.last_byte ? '0 : rem_nxt;
          end
        end
        default: state_r <= ST_BUILD;
      endcase
    end
  end

endmodule

@@ sv/rsp_queue.sv @@
// single-entry queue holding one finished remainder between front and back
// depends on rsp_pkg

module rsp_queue import rsp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  gf_vec_t wr_data,
  input  logic    rd_en,
  output logic    full,
  output gf_vec_t rd_data
);

  logic    valid_r;
  logic    valid_nxt;
  gf_vec_t data_r;

  assign valid_nxt = wr_en || (valid_r && !rd_en);
  assign full      = valid_r;
  assign rd_data   = data_r;

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      data_r <= wr_data;
    end
  end

endmodule

@@ sv/rsp_back.sv @@
// back end: shifts one remainder out as parity bytes, highest order first
// depends on rsp_pkg and rsp_out_if; loads from rsp_queue

module rsp_back import rsp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cnt_t    count,
  input  logic    q_full,
  input  gf_vec_t q_data,
  output logic    q_take,
  rsp_out_if.source out_ch
);

  cnt_t    left_r;
  cnt_t    left_nxt;
  gf_vec_t sh_r;
  logic    out_xfer;
  logic    last_out;

  assign last_out           = (left_r == cnt_t'(1));
  assign out_ch.valid       = (left_r != '0);
  assign out_ch.parity_byte = sh_r[0];
  assign out_ch.last_parity = last_out;
  assign out_xfer           = out_ch.valid && out_ch.ready;

  // load the next remainder once the current one is drained or finishing
  assign q_take = q_full && ((left_r == '0) || (last_out && out_xfer));

  always_comb begin
    left_nxt = left_r;
    if (q_take) begin
      left_nxt = count;
    end else if (out_xfer) begin
      left_nxt = left_r - cnt_t'(1);
    end
  end

  // remaining byte count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  // parity shift register
  always_ff @(posedge clk) begin
    if (q_take) begin
      sh_r <= q_data;
    end else if (out_xfer) begin
      sh_r <= sh_r >> 8;
    end
  end

endmodule

@@ sv/reed_solomon_parity_encoder.sv @@
// reed-solomon parity encoder over GF(256), polynomial 0x11d; takes one message byte per cycle
// while ready is high. a finished remainder waits in the queue until the back end loads it
// into its shift register; then parity_count bytes, one per cycle while out_ch is ready.
// input stalls while a remainder waits in the full queue. after reset (generator for 10 parity
// bytes) and each config write the generator is rebuilt while the input is held off.
// depends on rsp_pkg, rsp_in_if, rsp_out_if, rsp_front, rsp_queue, rsp_back

module reed_solomon_parity_encoder import rsp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  rsp_in_if.sink           in_ch,
  rsp_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  logic    q_wr_en;
  gf_vec_t q_wr_data;
  logic    q_full;
  logic    q_take;
  gf_vec_t q_rd_data;
  cnt_t    count;

  // byte intake and remainder lfsr
  rsp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .q_take     (q_take),
    .q_wr_en    (q_wr_en),
    .q_wr_data  (q_wr_data),
    .count      (count)
  );

  // finished remainder waiting for the back end
  rsp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_wr_en),
    .wr_data(q_wr_data),
    .rd_en  (q_take),
    .full   (q_full),
    .rd_data(q_rd_data)
  );

  // parity emission
  rsp_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .count (count),
    .q_full(q_full),
    .q_data(q_rd_data),
    .q_take(q_take),
    .out_ch(out_ch)
  );

endmodule

@@ tb/reed_solomon_parity_encoder_test.sv @@
// self-checking testbench for the reed-solomon parity encoder: random and directed messages,
// parity bytes predicted in GF(256) and compared in order on the parity channel
// depends on rsp_pkg, rsp_in_if, rsp_out_if and reed_solomon_parity_encoder

module reed_solomon_parity_encoder_test;
  import rsp_pkg::*;

  localparam int RANDOM_ITEMS  = 220;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int PRINT_LIMIT   = 40;

  typedef struct packed {
    gf_byte_t parity;
    logic     tail;
  } parity_rec_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  rsp_in_if  in_ch();
  rsp_out_if out_ch();

  reed_solomon_parity_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // encoder image: parity count, remainder and generator without its leading 1
  int          parity_len;
  gf_byte_t    rem_bytes [MAX_PARITY];
  gf_byte_t    gen_coef  [MAX_PARITY];
  parity_rec_t parity_due[$];

  bit idle_in  = 1'b1;
  bit idle_out = 1'b1;
  int cycle_count;
  int mismatches;
  int msgs_sent;
  int bytes_sent;
  int parity_checked;
  int count_writes;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // GF(256) product, lsb-first double and add
  function automatic gf_byte_t field_mul(gf_byte_t a, gf_byte_t b);
    gf_byte_t prod;
    gf_byte_t x;
    prod = 8'h00;
    x    = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) prod ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY_LO : 8'h00);
    end
    return prod;
  endfunction

  // generator = product of (x + alpha^i), i = 0 .. d-1; poly[k] holds the x^k term
  function automatic void build_gen_poly(int d);
    gf_byte_t poly [MAX_PARITY+1];
    gf_byte_t root;
    poly = '{default: 8'h00};
    poly[0] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < d; i++) begin
      for (int k = i + 1; k > 0; k--) poly[k] = poly[k-1] ^ field_mul(poly[k], root);
      poly[0] = field_mul(poly[0], root);
      root = field_mul(root, GF_ALPHA);
    end
    for (int j = 0; j < MAX_PARITY; j++) begin
      if (j < d) begin
        gen_coef[j] = poly[d-1-j];
      end else begin
        gen_coef[j] = 8'h00;
      end
    end
  endfunction

  // count write: saturate, rebuild generator, drop any partial message
  function automatic void load_parity_count(logic [CFG_W-1:0] v);
    if (v == '0) begin
      parity_len = 1;
    end else if (int'(v) > MAX_PARITY) begin
      parity_len = MAX_PARITY;
    end else begin
      parity_len = int'(v);
    end
    rem_bytes = '{default: 8'h00};
    build_gen_poly(parity_len);
  endfunction

  // one message byte through the division; the last byte releases the parity
  function automatic void absorb_byte(gf_byte_t b, logic last);
    gf_byte_t factor;
    factor = b ^ rem_bytes[0];
    for (int j = 0; j + 1 < parity_len; j++) rem_bytes[j] = rem_bytes[j+1];
    rem_bytes[parity_len-1] = 8'h00;
    for (int j = 0; j < parity_len; j++) rem_bytes[j] ^= field_mul(gen_coef[j], factor);
    if (last) begin
      for (int j = 0; j < parity_len; j++) parity_due.push_back({rem_bytes[j], j == parity_len - 1});
      rem_bytes = '{default: 8'h00};
      msgs_sent++;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    end
  endtask

  // one message byte transfer; valid stays high into the next call when no gap is drawn
  task automatic send_byte(input gf_byte_t b, input logic last);
    int gap;
    gap = idle_in ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    absorb_byte(b, last);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // hold the input until every parity byte is out and the block has gone quiet
  task automatic wait_parity_drained();
    end_burst();
    while (parity_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_parity_count(input logic [CFG_W-1:0] v);
    wait_parity_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    load_parity_count(v);
    count_writes++;
  endtask

  // parity channel: random stalls, each transfer compared with the oldest expectation
  initial begin
    int stall;
    parity_rec_t want;
    out_ch.ready = 1'b0;
    forever begin
      stall = idle_out ? $urandom_range(0, 7) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      parity_checked++;
      if (parity_due.size() == 0) begin
        report_mismatch("unexpected parity byte", out_ch.parity_byte, 0);
      end else begin
        want = parity_due.pop_front();
        if (out_ch.parity_byte !== want.parity) begin
          report_mismatch("parity_byte", out_ch.parity_byte, want.parity);
        end
        if (out_ch.last_parity !== want.tail) begin
          report_mismatch("last_parity", out_ch.last_parity, want.tail);
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d parity bytes outstanding", cycle_count,
             parity_due.size());
    $display("[reed_solomon_parity_encoder] ERROR");
    $finish;
  end

  // reset generator for ten parity bytes, no count write yet
  task automatic test_reset_generator();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  // smallest and largest counts, plus zero and over-range writes that saturate
  task automatic test_count_limits();
    write_parity_count(CFG_W'(1));
    idle_in  = 1'b0;
    idle_out = 1'b0;
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    idle_in  = 1'b1;
    idle_out = 1'b1;
    write_parity_count(CFG_W'(MAX_PARITY));
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    write_parity_count('0);
    send_byte(8'hC3, 1'b1);
    write_parity_count('1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h3C, 1'b1);
    write_parity_count(CFG_W'(MAX_PARITY + 1));
    send_byte(8'h7E, 1'b1);
  endtask

  // a count write in the middle of a message throws the partial remainder away
  task automatic test_partial_discard();
    write_parity_count(CFG_W'(5));
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    write_parity_count(CFG_W'(7));
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b1);
  endtask

  // phases of random messages under random counts; a phase may end mid-message
  task automatic test_random_messages();
    int budget;
    int in_phase;
    int msg_len;
    int k;
    int sel;
    logic [CFG_W-1:0] cnt_val;
    budget = RANDOM_ITEMS;
    while (budget > 0) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        cnt_val = $urandom_range(0, 1) ? '0 : CFG_W'($urandom_range(MAX_PARITY + 1, 63));
      end else if (sel <= 3) begin
        cnt_val = CFG_W'($urandom_range(1, 4));
      end else begin
        cnt_val = CFG_W'($urandom_range(1, MAX_PARITY));
      end
      write_parity_count(cnt_val);
      idle_in  = ($urandom_range(0, 3) != 0);
      idle_out = ($urandom_range(0, 3) != 0);
      in_phase = $urandom_range(15, 40);
      while (in_phase > 0 && budget > 0) begin
        msg_len = $urandom_range(1, 12);
        k = 0;
        while (k < msg_len && in_phase > 0 && budget > 0) begin
          send_byte(gf_byte_t'($urandom_range(0, 255)), k == msg_len - 1);
          k++;
          in_phase--;
          budget--;
        end
        // now and then hold off until all parity is back
        if ($urandom_range(0, 5) == 0) wait_parity_drained();
      end
    end
  endtask

  // test sequence
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    parity_len      = RESET_PARITY;
    rem_bytes       = '{default: 8'h00};
    build_gen_poly(parity_len);
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_generator();
    test_count_limits();
    test_partial_discard();
    test_random_messages();
    wait_parity_drained();

    $display("covered %0d messages of %0d bytes under %0d count writes", msgs_sent,
             bytes_sent, count_writes);
    $display("checked %0d parity bytes, %0d mismatches", parity_checked, mismatches);
    if (mismatches == 0) begin
      $display("[reed_solomon_parity_encoder] OK");
    end else begin
      $display("[reed_solomon_parity_encoder] ERROR");
    end
    $finish;
  end

endmodule
